// ----- rtl/core/lruc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and defaults of the LRU transaction ID cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

	localparam int DEF_CAPACITY = 512;
	localparam int DEF_BUCKETS  = 128;
	localparam int ID_W         = 64;
	localparam int FOLD_W       = 32;

	// request kinds
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] trans_id;
	} req_t;

	typedef struct packed {
		logic hit;
		logic evicted;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/lruc_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_ifs
// Valid/ready channels for requests and responses of the ID cache.
// ----------------------------------------------------------------------------
interface lruc_req_if
	import lruc_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lruc_rsp_if
	import lruc_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lruc_mod_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_mod_unit
// Remainder of a 32-bit fold by the bucket count, one byte per step.
// ----------------------------------------------------------------------------
module lruc_mod_unit
	import lruc_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FOLD_W-1:0] dividend,
	output logic                   done,
	output logic [BW-1:0]          rem
);

	// each step folds one byte into the running remainder, x = rem * 256 + byte,
	// and reduces x by reciprocal multiplication: exact for x below 2^20 and a
	// bucket count of at most 4096
	localparam int CHUNK_W = 8;
	localparam int STEPS   = FOLD_W / CHUNK_W;
	localparam int CW      = $clog2(STEPS);
	localparam int X_W     = 20;
	localparam int SHIFT   = 32;
	localparam int P_W     = X_W + SHIFT + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [SHIFT:0]  RECIP   = (SHIFT+1)'(RECIP_L);
	localparam logic [X_W-1:0]  DIVISOR = X_W'(BUCKETS);

	logic              busy_q;
	logic              done_q;
	logic              phase_q;
	logic [CW-1:0]     cnt_q;
	logic [FOLD_W-1:0] div_q;
	logic [BW-1:0]     rem_q;
	logic [X_W-1:0]    x_q;
	logic [X_W-1:0]    quo_q;
	logic [X_W-1:0]    x_next;
	logic [P_W-1:0]    prod;
	logic [X_W-1:0]    rem_full;

	// multiplies: quotient estimate by reciprocal, then remainder by multiply-subtract
	always_comb begin
		x_next   = {(X_W-CHUNK_W)'(rem_q), div_q[FOLD_W-1 -: CHUNK_W]};
		prod     = P_W'(x_next) * P_W'(RECIP);
		rem_full = x_q - quo_q * DIVISOR;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= busy_q && phase_q && (cnt_q == '0);
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(STEPS-1);
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				x_q   <= x_next;
				quo_q <= prod[X_W+SHIFT-1:SHIFT];
				div_q <= {div_q[FOLD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
			end else begin
				rem_q <= rem_full[BW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/lru_transaction_id_cache.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_transaction_id_cache
// Hashed set of recent 64-bit IDs with least-recently-used replacement.
// ----------------------------------------------------------------------------
// After reset the bucket heads are cleared to the empty mark, during which no
// request is taken. For each request the bucket index comes from a reciprocal
// remainder unit, each chain step is one registered read of the ID and link
// memories, and promoting or inserting then updates the memories. An insert
// into a full store first unlinks the oldest entry as victim, walking the
// victim's chain where it is not the head. The response sits in an output
// register, so the next request is taken while it waits.
module lru_transaction_id_cache
	import lruc_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int BUCKETS  = DEF_BUCKETS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lruc_req_if.sink    req,
	lruc_rsp_if.source  rsp
);

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [SW-1:0] NIL = SW'(CAPACITY);

	typedef enum logic [19:0] {
		ST_CLEAR   = 20'h00001,
		ST_IDLE    = 20'h00002,
		ST_DIV     = 20'h00004,
		ST_HEAD    = 20'h00008,
		ST_HLOAD   = 20'h00010,
		ST_CHECK   = 20'h00020,
		ST_CMP     = 20'h00040,
		ST_ALLOC   = 20'h00080,
		ST_EV_RD   = 20'h00100,
		ST_EV_HD   = 20'h00200,
		ST_EV_HCHK = 20'h00400,
		ST_EV_WALK = 20'h00800,
		ST_EV_WCMP = 20'h01000,
		ST_UNL_RD  = 20'h02000,
		ST_UNL_WR  = 20'h04000,
		ST_INS_RD  = 20'h08000,
		ST_INS_WR  = 20'h10000,
		ST_PUSH_A  = 20'h20000,
		ST_PUSH_B  = 20'h40000,
		ST_DONE    = 20'h80000
	} state_t;

	state_t state_q, state_d;

	// memories
	logic [ID_W-1:0] id_mem [CAPACITY];
	logic [BW-1:0]   sb_mem [CAPACITY];
	logic [SW-1:0]   cn_mem [CAPACITY];
	logic [SW-1:0]   ap_mem [CAPACITY];
	logic [SW-1:0]   an_mem [CAPACITY];
	logic [SW-1:0]   bh_mem [BUCKETS];

	logic [AW-1:0]   id_ra, sb_ra, cn_ra, ap_ra, an_ra;
	logic [BW-1:0]   bh_ra;
	logic [ID_W-1:0] id_rd;
	logic [BW-1:0]   sb_rd;
	logic [SW-1:0]   cn_rd, ap_rd, an_rd, bh_rd;

	logic            id_we, sb_we, cn_we, ap_we, an_we, bh_we;
	logic [AW-1:0]   id_wa, sb_wa, cn_wa, ap_wa, an_wa;
	logic [BW-1:0]   bh_wa;
	logic [SW-1:0]   cn_wd, ap_wd, an_wd, bh_wd;

	// request and walk registers
	logic            rtype_q;
	logic [ID_W-1:0] id_q;
	logic [BW-1:0]   bucket_q;
	logic [BW-1:0]   vbucket_q;
	logic [SW-1:0]   cur_q, slot_q, snext_q;
	logic [SW-1:0]   young_q, old_q, used_q;
	logic [BW-1:0]   clr_q;
	logic            hit_q, ev_q;
	logic            out_vld_q;
	rsp_t            out_q;

	logic            mod_start, mod_done;
	logic [BW-1:0]   mod_rem;

	logic            acc_in;
	assign acc_in    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign mod_start = acc_in;

	lruc_mod_unit #(.BUCKETS(BUCKETS)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req.data.trans_id[FOLD_W-1:0] | req.data.trans_id[ID_W-1:FOLD_W]),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// memory ports, registered reads
	always_ff @(posedge clk) begin
		id_rd <= id_mem[id_ra];
		sb_rd <= sb_mem[sb_ra];
		cn_rd <= cn_mem[cn_ra];
		ap_rd <= ap_mem[ap_ra];
		an_rd <= an_mem[an_ra];
		bh_rd <= bh_mem[bh_ra];
		if (id_we) id_mem[id_wa] <= id_q;
		if (sb_we) sb_mem[sb_wa] <= bucket_q;
		if (cn_we) cn_mem[cn_wa] <= cn_wd;
		if (ap_we) ap_mem[ap_wa] <= ap_wd;
		if (an_we) an_mem[an_wa] <= an_wd;
		if (bh_we) bh_mem[bh_wa] <= bh_wd;
	end

	// sequencer and memory control
	always_comb begin
		state_d = state_q;
		id_ra = slot_q[AW-1:0];
		sb_ra = slot_q[AW-1:0];
		cn_ra = slot_q[AW-1:0];
		ap_ra = slot_q[AW-1:0];
		an_ra = slot_q[AW-1:0];
		bh_ra = bucket_q;
		id_we = 1'b0; sb_we = 1'b0; cn_we = 1'b0;
		ap_we = 1'b0; an_we = 1'b0; bh_we = 1'b0;
		id_wa = slot_q[AW-1:0];
		sb_wa = slot_q[AW-1:0];
		cn_wa = slot_q[AW-1:0];
		ap_wa = slot_q[AW-1:0];
		an_wa = slot_q[AW-1:0];
		bh_wa = bucket_q;
		cn_wd = bh_rd;
		ap_wd = NIL;
		an_wd = young_q;
		bh_wd = slot_q;
		unique case (state_q)
			ST_CLEAR: begin
				bh_we = 1'b1;
				bh_wa = clr_q;
				bh_wd = NIL;
				if (clr_q == BW'(BUCKETS-1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (acc_in) state_d = ST_DIV;
			ST_DIV: if (mod_done) state_d = ST_HEAD;
			ST_HEAD: state_d = ST_HLOAD;
			ST_HLOAD: state_d = ST_CHECK;
			ST_CHECK: begin
				id_ra = cur_q[AW-1:0];
				cn_ra = cur_q[AW-1:0];
				if (cur_q == NIL) state_d = (rtype_q == REQ_INSERT) ? ST_ALLOC : ST_DONE;
				else state_d = ST_CMP;
			end
			ST_CMP: begin
				if (id_rd == id_q) state_d = (cur_q == young_q) ? ST_DONE : ST_UNL_RD;
				else state_d = ST_CHECK;
			end
			ST_ALLOC: state_d = (used_q < NIL) ? ST_INS_RD : ST_EV_RD;
			ST_EV_RD: state_d = ST_EV_HD;
			ST_EV_HD: begin
				bh_ra   = sb_rd;
				state_d = ST_EV_HCHK;
			end
			ST_EV_HCHK: begin
				if (bh_rd == slot_q) begin
					bh_we   = 1'b1;
					bh_wa   = vbucket_q;
					bh_wd   = snext_q;
					state_d = ST_UNL_RD;
				end else begin
					state_d = ST_EV_WALK;
				end
			end
			ST_EV_WALK: begin
				cn_ra   = cur_q[AW-1:0];
				state_d = (cur_q == NIL) ? ST_UNL_RD : ST_EV_WCMP;
			end
			ST_EV_WCMP: begin
				if (cn_rd == slot_q) begin
					cn_we   = 1'b1;
					cn_wa   = cur_q[AW-1:0];
					cn_wd   = snext_q;
					state_d = ST_UNL_RD;
				end else begin
					state_d = ST_EV_WALK;
				end
			end
			ST_UNL_RD: state_d = ST_UNL_WR;
			ST_UNL_WR: begin
				an_we   = (ap_rd != NIL);
				an_wa   = ap_rd[AW-1:0];
				an_wd   = an_rd;
				ap_we   = (an_rd != NIL);
				ap_wa   = an_rd[AW-1:0];
				ap_wd   = ap_rd;
				state_d = hit_q ? ST_PUSH_A : ST_INS_RD;
			end
			ST_INS_RD: state_d = ST_INS_WR;
			ST_INS_WR: begin
				id_we   = 1'b1;
				sb_we   = 1'b1;
				cn_we   = 1'b1;
				bh_we   = 1'b1;
				state_d = ST_PUSH_A;
			end
			ST_PUSH_A: begin
				an_we   = 1'b1;
				ap_we   = 1'b1;
				state_d = ST_PUSH_B;
			end
			ST_PUSH_B: begin
				ap_we   = (young_q != NIL);
				ap_wa   = young_q[AW-1:0];
				ap_wd   = slot_q;
				state_d = ST_DONE;
			end
			ST_DONE: if (!out_vld_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			young_q   <= NIL;
			old_q     <= NIL;
			used_q    <= '0;
			out_vld_q <= 1'b0;
			hit_q     <= 1'b0;
			ev_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			// output slot: loaded from the done state, emptied by a transfer
			if (state_q == ST_DONE && (!out_vld_q || rsp.ready)) out_vld_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					hit_q <= 1'b0;
					ev_q  <= 1'b0;
				end
				ST_CMP: if (id_rd == id_q) hit_q <= 1'b1;
				ST_ALLOC: begin
					if (used_q < NIL) used_q <= used_q + 1'b1;
					else ev_q <= 1'b1;
				end
				ST_UNL_WR: begin
					if (ap_rd == NIL) young_q <= an_rd;
					if (an_rd == NIL) old_q <= ap_rd;
				end
				ST_PUSH_B: begin
					if (young_q == NIL) old_q <= slot_q;
					young_q <= slot_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			rtype_q <= req.data.req_type;
			id_q    <= req.data.trans_id;
		end
		if (mod_done) bucket_q <= mod_rem;
		if (state_q == ST_HLOAD) cur_q <= bh_rd;
		if (state_q == ST_CMP) begin
			if (id_rd == id_q) slot_q <= cur_q;
			else cur_q <= cn_rd;
		end
		if (state_q == ST_ALLOC) slot_q <= (used_q < NIL) ? used_q : old_q;
		if (state_q == ST_EV_HD) begin
			vbucket_q <= sb_rd;
			snext_q   <= cn_rd;
		end
		if (state_q == ST_EV_HCHK) cur_q <= bh_rd;
		if (state_q == ST_EV_WCMP) cur_q <= cn_rd;
		if (state_q == ST_DONE && (!out_vld_q || rsp.ready)) begin
			out_q.hit     <= hit_q;
			out_q.evicted <= ev_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// checks
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> !req.ready)
		else $error("request taken while busy");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(young_q == NIL) == (old_q == NIL))
		else $error("age list ends disagree");

	a_used_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
		else $error("fill count moved other than by one");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
			((used_q <= NIL) && ((used_q == '0) == (young_q == NIL))))
		else $error("fill count and age list disagree");

	a_mod_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_DIV))
		else $error("hash result outside hash phase");

endmodule
`default_nettype wire
